[hw/rtl/spq_pkg.sv]
// ============================================================================
// spq_pkg
// Shared types, widths and constants of the stable priority queue.
// ============================================================================
package spq_pkg;

    // Field widths
    localparam int TAG_W  = 16;
    localparam int PRI_W  = 7;
    localparam int ROLE_W = 2;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Default number of held entries
    localparam int SPQ_DEPTH = 16;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((TAG_W + ROLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TAG_W + PRI_W + OCC_W + 7) / 8) * 8;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Role classes
    typedef enum logic [ROLE_W-1:0] {
        ROLE_TOP     = 2'd0,
        ROLE_FAMILY  = 2'd1,
        ROLE_SPONSOR = 2'd2,
        ROLE_OTHER   = 2'd3
    } role_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_req;       // capture the incoming request
        logic commit;         // apply enqueue/dequeue and load the result
        logic load_match;     // register the per-entry tag match vector
        logic report_lookup;  // reduce the match vector into a result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        req_t req_type;
    } dp_status_t;

    // Map a role class to its priority
    function automatic logic [PRI_W-1:0] role_priority(input role_t role);
        logic [PRI_W-1:0] pri;
        unique case (role)
            ROLE_TOP:     pri = PRI_W'(100);
            ROLE_FAMILY:  pri = PRI_W'(50);
            ROLE_SPONSOR: pri = PRI_W'(20);
            ROLE_OTHER:   pri = PRI_W'(1);
            default:      pri = PRI_W'(1);
        endcase
        return pri;
    endfunction

endpackage

[hw/rtl/spq_ctrl.sv]
// ============================================================================
// spq_ctrl
// Request sequencer: accepts one request, steps it through execute and,
// for lookups, the match reduction, and owns the result valid flag.
// ============================================================================
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t dp_stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result slot can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (dp_stat.req_type == REQ_LOOKUP)
                    state_next = S_REDUCE;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_REDUCE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            S_EXEC:
            begin
                if (dp_stat.req_type == REQ_LOOKUP)
                    cmd.load_match = 1'b1;
                else
                    cmd.commit = out_free;
            end
            S_REDUCE:
            begin
                cmd.report_lookup = out_free;
            end
            default: ;
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit || cmd.report_lookup)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[hw/rtl/spq_datapath.sv]
// ============================================================================
// spq_datapath
// Sorted row of entry cells, request capture, match vector and result
// register. Each cell decides locally whether it keeps, shifts or loads.
// ============================================================================
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    input  cmd_t                 cmd,
    output dp_status_t           dp_stat,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]    m_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    // Captured request
    req_t             req_type_reg;
    logic [TAG_W-1:0] req_tag_reg;
    logic [PRI_W-1:0] req_pri_reg;

    // Entry cells
    logic [TAG_W-1:0] tag_reg  [DEPTH];
    logic [TAG_W-1:0] tag_next [DEPTH];
    logic [PRI_W-1:0] pri_reg  [DEPTH];
    logic [PRI_W-1:0] pri_next [DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] ge_prev;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] match_reg;
    logic             full;
    logic             empty;

    // Result register
    status_t          res_status_reg;
    status_t          res_status_next;
    logic [TAG_W-1:0] res_tag_reg;
    logic [TAG_W-1:0] res_tag_next;
    logic [PRI_W-1:0] res_pri_reg;
    logic [PRI_W-1:0] res_pri_next;
    logic [OCC_W-1:0] res_occ_reg;
    logic [OCC_W-1:0] res_occ_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Per-cell occupancy, priority compare and tag match
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid[i] = (CW'(i) < count_reg);
            ge[i]    = valid[i] && (pri_reg[i] >= req_pri_reg);
            match[i] = valid[i] && (tag_reg[i] == req_tag_reg);
        end
    end

    // Left neighbor's compare; the head cell sees a virtual higher entry
    assign ge_prev = {ge[DEPTH-2:0], 1'b1};

    // Next cell contents and result
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_next[i] = tag_reg[i];
            pri_next[i] = pri_reg[i];
        end
        count_next      = count_reg;
        res_status_next = ST_OK;
        res_tag_next    = '0;
        res_pri_next    = '0;

        if (cmd.commit)
        begin
            unique case (req_type_reg)
                REQ_ENQ:
                begin
                    if (full)
                        res_status_next = ST_FULL;
                    else
                    begin
                        // Keep higher-or-equal entries, insert, shift the rest
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (!ge[i])
                            begin
                                if (ge_prev[i])
                                begin
                                    tag_next[i] = req_tag_reg;
                                    pri_next[i] = req_pri_reg;
                                end
                                else if (i > 0)
                                begin
                                    tag_next[i] = tag_reg[(i > 0) ? i - 1 : 0];
                                    pri_next[i] = pri_reg[(i > 0) ? i - 1 : 0];
                                end
                            end
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_DEQ:
                begin
                    if (empty)
                        res_status_next = ST_EMPTY;
                    else
                    begin
                        res_tag_next = tag_reg[0];
                        res_pri_next = pri_reg[0];
                        // Advance every entry one cell toward the head
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            tag_next[i] = tag_reg[i + 1];
                            pri_next[i] = pri_reg[i + 1];
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
                REQ_LOOKUP: ;
                REQ_NONE:   ;
                default:    ;
            endcase
        end
        else if (cmd.report_lookup)
        begin
            res_status_next = (|match_reg) ? ST_OK : ST_NOT_FOUND;
        end

        res_occ_next = OCC_W'(count_next);
    end

    // Request capture and cell payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_t'(s_tuser);
            req_tag_reg  <= s_tdata[TAG_W-1:0];
            req_pri_reg  <= role_priority(role_t'(s_tdata[TAG_W +: ROLE_W]));
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_reg[i] <= tag_next[i];
            pri_reg[i] <= pri_next[i];
        end
        if (cmd.load_match)
            match_reg <= match;
        if (cmd.commit || cmd.report_lookup)
        begin
            res_status_reg <= res_status_next;
            res_tag_reg    <= res_tag_next;
            res_pri_reg    <= res_pri_next;
            res_occ_reg    <= res_occ_next;
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign dp_stat.req_type = req_type_reg;

    assign m_tdata = M_TDATA_W'({res_occ_reg, res_pri_reg, res_tag_reg});
    assign m_tuser = res_status_reg;

endmodule

[hw/rtl/stable_priority_queue.sv]
// ============================================================================
// stable_priority_queue
// Bounded priority queue, sorted by priority, first-in first-out within
// equal priority.
// ============================================================================
// Every request gives exactly one result. Enqueue, dequeue and the unused
// request code are captured on acceptance, then pass an execute step in which
// every entry cell keeps, shifts or loads in parallel and the result register
// loads; a tag lookup adds a reduction step, as its per-entry match vector is
// registered before it is reduced. One request is in flight at a time, and the
// next is accepted while the previous result still waits in the output
// register. A result that is not taken holds the execute step, or for a
// lookup the reduction step, until the output register frees. An enqueue
// into a full queue is rejected with a full status and leaves the queue
// unchanged. occupancy is the low 5 bits of the entry count after the request.
// ============================================================================
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // guest_tag[15:0], role_class[17:16]
    input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // tag_out[15:0], priority_out[22:16],
                                            // occupancy[27:23]
    output logic [STAT_W-1:0]    m_tuser    // status[1:0]
);

    cmd_t       cmd;
    dp_status_t dp_stat;

    // Request sequencer
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // Sorted entry row and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .dp_stat (dp_stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
